### design/olio_pkg.sv
// olio_pkg: shared types and constants for the ordered list with index operations
// holds command, status and state codes plus the structs between controller and datapath
// no dependencies
package olio_pkg;

  localparam int unsigned OLIO_CAPACITY    = 64;
  localparam int unsigned OLIO_ENTRY_WIDTH = 32;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned PORT_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_READ   = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_ROTATE = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE  = 2'd0,
    STS_RANGE = 2'd1,
    STS_FULL  = 2'd2,
    STS_FEW   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_ROTATE,
    ST_FINISH
  } state_e;

  // write address source
  typedef enum logic [1:0] {
    WA_BACK,
    WA_FRONT,
    WA_IDX
  } wa_e;

  // read address source
  typedef enum logic [1:0] {
    RA_FRONT,
    RA_POS,
    RA_POS_NEXT,
    RA_IDX_NEXT2
  } ra_e;

  typedef struct packed {
    logic    mem_we;
    wa_e     wa_sel;
    logic    wd_entry;
    logic    rd_en;
    ra_e     ra_sel;
    logic    head_inc;
    logic    head_dec;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    idx_load;
    logic    idx_inc;
    logic    res_load;
    logic    res_use_rd;
    status_e res_status;
  } ctl_t;

  typedef struct packed {
    logic full;
    logic few;
    logic pos_ok;
    logic pos_last;
    logic shift_last;
  } sts_t;

endpackage

### design/olio_dp.sv
// olio_dp: datapath of the ordered list, circular entry memory with head and count
// registers, address wrap, shift index and result registers
// depends on olio_pkg
module olio_dp #(
  parameter int unsigned CAPACITY    = olio_pkg::OLIO_CAPACITY,
  parameter int unsigned ENTRY_WIDTH = olio_pkg::OLIO_ENTRY_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  olio_pkg::ctl_t                 ctl_i,
  output olio_pkg::sts_t                 sts_o,
  input  logic [olio_pkg::POS_W-1:0]     position_i,
  input  logic [olio_pkg::PORT_W-1:0]    entry_i,
  output logic [olio_pkg::STATUS_W-1:0]  status_o,
  output logic [olio_pkg::PORT_W-1:0]    read_entry_o,
  output logic [olio_pkg::COUNT_W-1:0]   entry_count_o
);
  import olio_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned OW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [ENTRY_WIDTH-1:0] mem_q [CAPACITY];
  logic [ENTRY_WIDTH-1:0] rd_data_q;
  logic [AW-1:0]          head_q, head_d;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic [AW-1:0]          head_prev, head_next;
  logic [OW-1:0]          wr_off, rd_off;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic [ENTRY_WIDTH-1:0] wr_data;
  logic [STATUS_W-1:0]    status_q;
  logic [PORT_W-1:0]      read_entry_q;
  logic [COUNT_W-1:0]     entry_count_q;

  function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
                                               input logic [OW-1:0] off);
    logic [OW-1:0] sum;
    sum = OW'(base) + off;
    if (sum >= OW'(CAPACITY)) begin
      sum = sum - OW'(CAPACITY);
    end
    return AW'(sum);
  endfunction

  assign head_prev = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - AW'(1);
  assign head_next = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + AW'(1);

  always_comb begin
    case (ctl_i.wa_sel)
      WA_BACK: wr_off = OW'(count_q);
      WA_IDX:  wr_off = OW'(idx_q);
      default: wr_off = '0;
    endcase
    case (ctl_i.ra_sel)
      RA_POS:       rd_off = OW'(position_i);
      RA_POS_NEXT:  rd_off = OW'(position_i) + OW'(1);
      RA_IDX_NEXT2: rd_off = OW'(idx_q) + OW'(2);
      default:      rd_off = '0;
    endcase
  end

  assign wr_addr = (ctl_i.wa_sel == WA_FRONT) ? head_prev : wrap_addr(head_q, wr_off);
  assign rd_addr = wrap_addr(head_q, rd_off);
  assign wr_data = ctl_i.wd_entry ? ENTRY_WIDTH'(entry_i) : rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    idx_d   = idx_q;
    if (ctl_i.head_inc) begin
      head_d = head_next;
    end else if (ctl_i.head_dec) begin
      head_d = head_prev;
    end
    if (ctl_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (ctl_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
    if (ctl_i.idx_load) begin
      idx_d = CW'(position_i);
    end else if (ctl_i.idx_inc) begin
      idx_d = idx_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.res_load) begin
      status_q      <= ctl_i.res_status;
      read_entry_q  <= ctl_i.res_use_rd ? PORT_W'(rd_data_q) : '0;
      entry_count_q <= COUNT_W'(count_q);
    end
  end

  assign sts_o.full       = (count_q == CW'(CAPACITY));
  assign sts_o.few        = (count_q < CW'(2));
  assign sts_o.pos_ok     = (OW'(position_i) < OW'(count_q));
  assign sts_o.pos_last   = (OW'(position_i) + OW'(1) == OW'(count_q));
  assign sts_o.shift_last = (OW'(idx_q) + OW'(2) == OW'(count_q));

  assign status_o      = status_q;
  assign read_entry_o  = read_entry_q;
  assign entry_count_o = entry_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= AW'(CAPACITY - 1))
    else $error("head pointer beyond capacity");

  a_no_grow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.cnt_inc |-> !sts_o.full)
    else $error("entry added to a full list");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.mem_we && ctl_i.rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write at the same slot");

endmodule

### design/olio_ctrl.sv
// olio_ctrl: controller state machine of the ordered list
// decodes commands, sequences delete shifts and rotate, owns the handshakes
// depends on olio_pkg
module olio_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [olio_pkg::CMD_W-1:0]  command_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  input  olio_pkg::sts_t              sts_i,
  output olio_pkg::ctl_t              ctl_o
);
  import olio_pkg::*;

  state_e  state_q, state_d;
  status_e status_q, status_d;
  logic    use_rd_q, use_rd_d;
  logic    out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      status_q    <= STS_DONE;
      use_rd_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      use_rd_q    <= use_rd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    ctl_o       = '0;
    state_d     = state_q;
    status_d    = status_q;
    use_rd_d    = use_rd_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d  = ST_FINISH;
          status_d = STS_DONE;
          use_rd_d = 1'b0;
          case (cmd_e'(command_i))
            CMD_APPEND: begin
              if (sts_i.full) begin
                status_d = STS_FULL;
              end else begin
                ctl_o.mem_we   = 1'b1;
                ctl_o.wa_sel   = WA_BACK;
                ctl_o.wd_entry = 1'b1;
                ctl_o.cnt_inc  = 1'b1;
              end
            end
            CMD_INSERT: begin
              if (sts_i.full) begin
                status_d = STS_FULL;
              end else begin
                ctl_o.mem_we   = 1'b1;
                ctl_o.wa_sel   = WA_FRONT;
                ctl_o.wd_entry = 1'b1;
                ctl_o.head_dec = 1'b1;
                ctl_o.cnt_inc  = 1'b1;
              end
            end
            CMD_READ: begin
              if (!sts_i.pos_ok) begin
                status_d = STS_RANGE;
              end else begin
                ctl_o.rd_en  = 1'b1;
                ctl_o.ra_sel = RA_POS;
                use_rd_d     = 1'b1;
              end
            end
            CMD_DELETE: begin
              if (!sts_i.pos_ok) begin
                status_d = STS_RANGE;
              end else if (sts_i.pos_last) begin
                ctl_o.cnt_dec = 1'b1;
              end else begin
                ctl_o.rd_en    = 1'b1;
                ctl_o.ra_sel   = RA_POS_NEXT;
                ctl_o.idx_load = 1'b1;
                state_d        = ST_SHIFT;
              end
            end
            CMD_ROTATE: begin
              if (sts_i.few) begin
                status_d = STS_FEW;
              end else begin
                ctl_o.rd_en  = 1'b1;
                ctl_o.ra_sel = RA_FRONT;
                state_d      = ST_ROTATE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SHIFT: begin
        ctl_o.mem_we = 1'b1;
        ctl_o.wa_sel = WA_IDX;
        if (sts_i.shift_last) begin
          ctl_o.cnt_dec = 1'b1;
          state_d       = ST_FINISH;
        end else begin
          ctl_o.rd_en   = 1'b1;
          ctl_o.ra_sel  = RA_IDX_NEXT2;
          ctl_o.idx_inc = 1'b1;
        end
      end
      ST_ROTATE: begin
        ctl_o.mem_we   = 1'b1;
        ctl_o.wa_sel   = WA_BACK;
        ctl_o.head_inc = 1'b1;
        state_d        = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          ctl_o.res_load   = 1'b1;
          ctl_o.res_use_rd = use_rd_q;
          ctl_o.res_status = status_q;
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_finish_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_valid_q && out_stall_i) |=> state_q == ST_FINISH)
    else $error("result dropped while output stalled");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.res_load |=> out_valid_q)
    else $error("result loaded without valid");

endmodule

### design/ordered_list_with_index_ops_top.sv
// ordered_list_with_index_ops_top: bounded ordered list with append, insert, indexed read,
// indexed delete and rotate; one command in flight, result held in an output register.
// rotate runs through the rotate state and a delete short of the last entry through the
// shift state (one memory read/write port pair moves one entry a cycle); the rest go
// from idle to finish; a new command is taken the cycle after its result is registered.
// reset clears count, head and handshake state; entry memory has no reset and no clear pass
module ordered_list_with_index_ops_top #(
  parameter int unsigned CAPACITY    = olio_pkg::OLIO_CAPACITY,
  parameter int unsigned ENTRY_WIDTH = olio_pkg::OLIO_ENTRY_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [olio_pkg::CMD_W-1:0]     command_i,
  input  logic [olio_pkg::POS_W-1:0]     position_i,
  input  logic [olio_pkg::PORT_W-1:0]    entry_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [olio_pkg::STATUS_W-1:0]  status_o,
  output logic [olio_pkg::PORT_W-1:0]    read_entry_o,
  output logic [olio_pkg::COUNT_W-1:0]   entry_count_o
);
  import olio_pkg::*;

  ctl_t ctl;
  sts_t sts;

  olio_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  olio_dp #(
    .CAPACITY    (CAPACITY),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .position_i    (position_i),
    .entry_i       (entry_i),
    .status_o      (status_o),
    .read_entry_o  (read_entry_o),
    .entry_count_o (entry_count_o)
  );

endmodule
